[sv/ssbs_pkg.sv]
// Shared constants, codes and structs of the sorted strike bound search.
`default_nettype none
package ssbs_pkg;

	localparam int MAX_STRIKES = 256;
	localparam int PRICE_BITS  = 24;
	localparam int STRIKE_BITS = 24;
	localparam int FUNC_BITS   = 3;
	localparam int STATUS_BITS = 2;
	localparam int IDX_BITS    = $clog2(MAX_STRIKES);
	localparam int CNT_BITS    = IDX_BITS + 1;

	localparam logic [FUNC_BITS-1:0] FN_INSERT      = 3'd0;
	localparam logic [FUNC_BITS-1:0] FN_ABOVE       = 3'd1;
	localparam logic [FUNC_BITS-1:0] FN_AT_OR_ABOVE = 3'd2;
	localparam logic [FUNC_BITS-1:0] FN_NEAREST     = 3'd3;
	localparam logic [FUNC_BITS-1:0] FN_AT_OR_BELOW = 3'd4;
	localparam logic [FUNC_BITS-1:0] FN_BELOW       = 3'd5;

	localparam logic [STATUS_BITS-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [STATUS_BITS-1:0] ST_START     = 2'd2;
	localparam logic [STATUS_BITS-1:0] ST_FULL      = 2'd3;

	typedef struct packed {
		logic                  rd_en;
		logic [IDX_BITS-1:0]   rd_addr;
		logic                  wr_en;
		logic [IDX_BITS-1:0]   wr_addr;
		logic [PRICE_BITS-1:0] wr_data;
	} mem_req_t;

	typedef struct packed {
		logic [PRICE_BITS-1:0] a;
		logic [PRICE_BITS-1:0] b;
	} alu_req_t;

	typedef struct packed {
		logic [PRICE_BITS-1:0] diff;
		logic                  borrow;
		logic                  zero;
	} alu_res_t;

	typedef struct packed {
		logic                   valid;
		logic [PRICE_BITS-1:0]  strike;
		logic [STATUS_BITS-1:0] status;
	} res_t;

endpackage
`default_nettype wire

[sv/ssbs_in_if.sv]
// Request channel: function code and price.
`default_nettype none
interface ssbs_in_if;
	logic                            valid;
	logic                            ready;
	logic [ssbs_pkg::FUNC_BITS-1:0]  func;
	logic [ssbs_pkg::PRICE_BITS-1:0] price;

	modport source (output valid, output func, output price, input ready);
	modport sink   (input valid, input func, input price, output ready);
endinterface
`default_nettype wire

[sv/ssbs_out_if.sv]
// Result channel: selected strike and status.
`default_nettype none
interface ssbs_out_if;
	logic                             valid;
	logic                             ready;
	logic [ssbs_pkg::STRIKE_BITS-1:0] strike;
	logic [ssbs_pkg::STATUS_BITS-1:0] status;

	modport source (output valid, output strike, output status, input ready);
	modport sink   (input valid, input strike, input status, output ready);
endinterface
`default_nettype wire

[sv/ssbs_table.sv]
// Strike table memory: one write port, one registered read port.
`default_nettype none
module ssbs_table (
	input  wire logic                            clk,
	input  wire ssbs_pkg::mem_req_t              mem,
	output logic [ssbs_pkg::PRICE_BITS-1:0]      rd_data
);

	logic [ssbs_pkg::PRICE_BITS-1:0] table_q [ssbs_pkg::MAX_STRIKES];
	logic [ssbs_pkg::PRICE_BITS-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (mem.wr_en) begin
			table_q[mem.wr_addr] <= mem.wr_data;
		end
		if (mem.rd_en) begin
			rd_data_q <= table_q[mem.rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
`default_nettype wire

[sv/ssbs_alu.sv]
// Shared subtractor: difference, borrow (a < b) and equality.
`default_nettype none
module ssbs_alu (
	input  wire ssbs_pkg::alu_req_t  req,
	output ssbs_pkg::alu_res_t       res
);

	logic [ssbs_pkg::PRICE_BITS:0] diff_ext;

	assign diff_ext   = {1'b0, req.a} - {1'b0, req.b};
	assign res.diff   = diff_ext[ssbs_pkg::PRICE_BITS-1:0];
	assign res.borrow = diff_ext[ssbs_pkg::PRICE_BITS];
	assign res.zero   = (diff_ext[ssbs_pkg::PRICE_BITS-1:0] == '0);

endmodule
`default_nettype wire

[sv/ssbs_seq.sv]
// Sequencer: binary search, insert shift and bound selection.
`default_nettype none
module ssbs_seq (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              req_valid,
	output logic                                   req_ready,
	input  wire logic [ssbs_pkg::FUNC_BITS-1:0]    req_func,
	input  wire logic [ssbs_pkg::PRICE_BITS-1:0]   req_price,
	output ssbs_pkg::mem_req_t                     mem,
	input  wire logic [ssbs_pkg::PRICE_BITS-1:0]   rd_data,
	output ssbs_pkg::alu_req_t                     alu_req,
	input  wire ssbs_pkg::alu_res_t                alu_res,
	input  wire logic                              out_free,
	output ssbs_pkg::res_t                         res
);

	typedef enum logic [10:0] {
		S_IDLE  = 11'b000_0000_0001,
		S_SRCH  = 11'b000_0000_0010,
		S_CMP   = 11'b000_0000_0100,
		S_GETK  = 11'b000_0000_1000,
		S_GETL  = 11'b000_0001_0000,
		S_DIST1 = 11'b000_0010_0000,
		S_DIST2 = 11'b000_0100_0000,
		S_SHRD  = 11'b000_1000_0000,
		S_SHWR  = 11'b001_0000_0000,
		S_PUT   = 11'b010_0000_0000,
		S_FIN   = 11'b100_0000_0000
	} state_t;

	state_t state_q, state_d;

	logic [ssbs_pkg::CNT_BITS-1:0]    count_q;
	logic [ssbs_pkg::FUNC_BITS-1:0]   func_q;
	logic [ssbs_pkg::PRICE_BITS-1:0]  price_q;
	logic [ssbs_pkg::CNT_BITS-1:0]    lo_q, hi_q, mid_q, k_q, j_q;
	logic [ssbs_pkg::PRICE_BITS-1:0]  hiv_q, lov_q, d1_q, d2_q;
	logic [ssbs_pkg::PRICE_BITS-1:0]  res_strike_q;
	logic [ssbs_pkg::STATUS_BITS-1:0] res_status_q;

	logic [ssbs_pkg::CNT_BITS-1:0]    mid, km1, jm1;
	logic                             k_in, k_zero, full, go_right;
	logic                             set_res;
	logic [ssbs_pkg::PRICE_BITS-1:0]  res_strike_d;
	logic [ssbs_pkg::STATUS_BITS-1:0] res_status_d;

	assign mid      = lo_q + ((hi_q - lo_q) >> 1);
	assign km1      = k_q - ssbs_pkg::CNT_BITS'(1);
	assign jm1      = j_q - ssbs_pkg::CNT_BITS'(1);
	assign k_in     = (k_q < count_q);
	assign k_zero   = (k_q == '0);
	assign full     = (count_q == ssbs_pkg::CNT_BITS'(ssbs_pkg::MAX_STRIKES));
	// upper-bound search for "above", lower-bound for everything else
	assign go_right = alu_res.borrow || ((func_q == ssbs_pkg::FN_ABOVE) && alu_res.zero);

	assign req_ready  = (state_q == S_IDLE);
	assign res.valid  = (state_q == S_FIN);
	assign res.strike = res_strike_q;
	assign res.status = res_status_q;

	// memory port
	always_comb begin
		mem.rd_en   = 1'b0;
		mem.rd_addr = mid[ssbs_pkg::IDX_BITS-1:0];
		mem.wr_en   = 1'b0;
		mem.wr_addr = j_q[ssbs_pkg::IDX_BITS-1:0];
		mem.wr_data = rd_data;
		case (state_q)
			S_SRCH: begin
				mem.rd_en   = 1'b1;
				mem.rd_addr = (lo_q < hi_q) ? mid[ssbs_pkg::IDX_BITS-1:0]
				                            : lo_q[ssbs_pkg::IDX_BITS-1:0];
			end
			S_GETK: begin
				mem.rd_en   = 1'b1;
				mem.rd_addr = km1[ssbs_pkg::IDX_BITS-1:0];
			end
			S_SHRD: begin
				mem.rd_en   = 1'b1;
				mem.rd_addr = jm1[ssbs_pkg::IDX_BITS-1:0];
			end
			S_SHWR: begin
				mem.wr_en   = 1'b1;
			end
			S_PUT: begin
				mem.wr_en   = 1'b1;
				mem.wr_addr = k_q[ssbs_pkg::IDX_BITS-1:0];
				mem.wr_data = price_q;
			end
			default: begin
				mem.rd_en   = 1'b0;
			end
		endcase
	end

	// subtractor operands
	always_comb begin
		case (state_q)
			S_GETL: begin
				alu_req.a = hiv_q;
				alu_req.b = price_q;
			end
			S_DIST1: begin
				alu_req.a = price_q;
				alu_req.b = lov_q;
			end
			S_DIST2: begin
				alu_req.a = d1_q;
				alu_req.b = d2_q;
			end
			default: begin
				alu_req.a = rd_data;
				alu_req.b = price_q;
			end
		endcase
	end

	// next state and result
	always_comb begin
		state_d      = state_q;
		set_res      = 1'b0;
		res_strike_d = '0;
		res_status_d = ssbs_pkg::ST_OK;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					if (req_func > ssbs_pkg::FN_BELOW) begin
						set_res      = 1'b1;
						res_status_d = ssbs_pkg::ST_NOT_FOUND;
						state_d      = S_FIN;
					end else begin
						state_d = S_SRCH;
					end
				end
			end
			S_SRCH: begin
				state_d = (lo_q < hi_q) ? S_CMP : S_GETK;
			end
			S_CMP: begin
				state_d = S_SRCH;
			end
			S_GETK: begin
				if (!k_in) begin
					set_res = 1'b1;
					state_d = S_FIN;
					if (func_q != ssbs_pkg::FN_INSERT) begin
						res_status_d = ssbs_pkg::ST_NOT_FOUND;
					end else if (full) begin
						res_status_d = ssbs_pkg::ST_FULL;
					end else begin
						set_res = 1'b0;
						state_d = S_PUT;
					end
				end else begin
					case (func_q)
						ssbs_pkg::FN_INSERT: begin
							if (alu_res.zero) begin
								set_res      = 1'b1;
								res_strike_d = price_q;
								state_d      = S_FIN;
							end else if (full) begin
								set_res      = 1'b1;
								res_status_d = ssbs_pkg::ST_FULL;
								state_d      = S_FIN;
							end else begin
								state_d = S_SHRD;
							end
						end
						ssbs_pkg::FN_ABOVE, ssbs_pkg::FN_AT_OR_ABOVE: begin
							set_res      = 1'b1;
							res_strike_d = rd_data;
							state_d      = S_FIN;
						end
						ssbs_pkg::FN_NEAREST: begin
							if (alu_res.zero || k_zero) begin
								set_res      = 1'b1;
								res_strike_d = rd_data;
								state_d      = S_FIN;
							end else begin
								state_d = S_GETL;
							end
						end
						default: begin
							if ((func_q == ssbs_pkg::FN_AT_OR_BELOW) && alu_res.zero) begin
								set_res      = 1'b1;
								res_strike_d = rd_data;
								state_d      = S_FIN;
							end else if (k_zero) begin
								set_res      = 1'b1;
								res_status_d = ssbs_pkg::ST_START;
								state_d      = S_FIN;
							end else begin
								state_d = S_GETL;
							end
						end
					endcase
				end
			end
			S_GETL: begin
				if (func_q == ssbs_pkg::FN_NEAREST) begin
					state_d = S_DIST1;
				end else begin
					set_res      = 1'b1;
					res_strike_d = rd_data;
					state_d      = S_FIN;
				end
			end
			S_DIST1: begin
				state_d = S_DIST2;
			end
			S_DIST2: begin
				// upper wins only when strictly closer
				set_res      = 1'b1;
				res_strike_d = alu_res.borrow ? hiv_q : lov_q;
				state_d      = S_FIN;
			end
			S_SHRD: begin
				state_d = S_SHWR;
			end
			S_SHWR: begin
				state_d = (jm1 > k_q) ? S_SHRD : S_PUT;
			end
			S_PUT: begin
				set_res      = 1'b1;
				res_strike_d = price_q;
				state_d      = S_FIN;
			end
			S_FIN: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_PUT) begin
				count_q <= count_q + ssbs_pkg::CNT_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				func_q  <= req_func;
				price_q <= req_price;
				lo_q    <= '0;
				hi_q    <= count_q;
			end
			S_SRCH: begin
				mid_q <= mid;
				k_q   <= lo_q;
			end
			S_CMP: begin
				if (go_right) begin
					lo_q <= mid_q + ssbs_pkg::CNT_BITS'(1);
				end else begin
					hi_q <= mid_q;
				end
			end
			S_GETK: begin
				hiv_q <= rd_data;
				j_q   <= count_q;
			end
			S_GETL: begin
				lov_q <= rd_data;
				d1_q  <= alu_res.diff;
			end
			S_DIST1: begin
				d2_q <= alu_res.diff;
			end
			S_SHWR: begin
				j_q <= jm1;
			end
			default: begin
				j_q <= j_q;
			end
		endcase
		if (set_res) begin
			res_strike_q <= res_strike_d;
			res_status_q <= res_status_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= ssbs_pkg::CNT_BITS'(ssbs_pkg::MAX_STRIKES))
		else $error("strike count beyond table depth");
	a_search_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SRCH) |-> (lo_q <= hi_q))
		else $error("search bounds crossed");
	a_put_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PUT) |-> !full)
		else $error("insert into full table");
	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_PUT) |=> $stable(count_q))
		else $error("strike count moved outside insert");
`endif

endmodule
`default_nettype wire

[sv/sorted_strike_bound_search.sv]
// Top level of the sorted strike bound search.
//
// req carries one request: func (0 insert, 1 above, 2 at or above, 3 nearest,
// 4 at or below, 5 below) and price in cents. rsp returns exactly one result
// per request: strike and status (0 ok, 1 not found, 2 start of chain,
// 3 table full). Both channels use valid/ready; a transfer happens on a
// clock edge with both high.
// One request is in work at a time. A query runs a binary search over the
// strike table, each halving a memory read, then a compare in the shared
// subtractor; nearest may then read the lower neighbour, form both distances
// and compare them. An insert that adds a new strike also moves every
// larger strike up one slot, each moved entry first read, then written back.
// The result lands in an output register; the next request is taken while
// it waits, but the block holds its own next result until rsp is taken.
// A stalled receiver therefore stops the block after one result in flight.
// Reset (arst_n low, asynchronous) empties the table by clearing the strike
// count; no memory clearing pass is needed, and req is ready right after.
`default_nettype none
module sorted_strike_bound_search (
	input  wire logic  clk,
	input  wire logic  arst_n,
	ssbs_in_if.sink    req,
	ssbs_out_if.source rsp
);

	ssbs_pkg::mem_req_t                mem;
	ssbs_pkg::alu_req_t                alu_req;
	ssbs_pkg::alu_res_t                alu_res;
	ssbs_pkg::res_t                    res;
	logic [ssbs_pkg::PRICE_BITS-1:0]   rd_data;
	logic                              out_free;

	// output register, parts the sequencer from the receiver
	logic                              rsp_valid_q;
	logic [ssbs_pkg::STRIKE_BITS-1:0]  rsp_strike_q;
	logic [ssbs_pkg::STATUS_BITS-1:0]  rsp_status_q;

	assign out_free = !rsp_valid_q || rsp.ready;

	ssbs_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.req_func  (req.func),
		.req_price (req.price),
		.mem       (mem),
		.rd_data   (rd_data),
		.alu_req   (alu_req),
		.alu_res   (alu_res),
		.out_free  (out_free),
		.res       (res)
	);

	ssbs_table u_table (
		.clk     (clk),
		.mem     (mem),
		.rd_data (rd_data)
	);

	ssbs_alu u_alu (
		.req (alu_req),
		.res (alu_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res.valid && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid && out_free) begin
			rsp_strike_q <= ssbs_pkg::STRIKE_BITS'(res.strike);
			rsp_status_q <= res.status;
		end
	end

	assign rsp.valid  = rsp_valid_q;
	assign rsp.strike = rsp_strike_q;
	assign rsp.status = rsp_status_q;

endmodule
`default_nettype wire
